FILE: hw/rtl/ssat_pkg.sv
`default_nettype none

package ssat_pkg;

    // Index width of the token buffer and input counter
    localparam int INDEX_BITS_DEF = 16;

    // Result queue depth (power of two)
    localparam int OQ_DEPTH = 4;

    // Reset value of the buffer limit register
    localparam logic [16:0] BUF_LIMIT_RST = 17'h10000;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_T   = 8'h74;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    // Line status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNTERM   = 2'd1;
    localparam logic [1:0] ST_BUF_FULL = 2'd2;

    // One result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] token_start;
        logic [16:0] token_length;
        logic [1:0]  status;
        logic [15:0] error_position;
        logic        last_of_run;
    } res_t;

    // Results produced by one accepted input byte
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssat_lexer.sv
`default_nettype none

module ssat_lexer
    import ssat_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_data,
    output push_t            push
);

    localparam int W  = INDEX_BITS;
    localparam int CW = (W + 1 > 17) ? W + 1 : 17;
    localparam logic [W:0]   BUF_MAX = {1'b1, {W{1'b0}}};
    localparam logic [W-1:0] IDX_MAX = {W{1'b1}};

    typedef enum logic [2:0] {
        M_BETWEEN  = 3'd0,
        M_WORD     = 3'd1,
        M_WORD_ESC = 3'd2,
        M_SQ       = 3'd3,
        M_DQ       = 3'd4,
        M_DQ_ESC   = 3'd5,
        M_ERROR    = 3'd6
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [W:0]   wc_reg, wc_next;
    logic [W:0]   cts_reg, cts_next;
    logic [W-1:0] idx_reg, idx_next;
    logic [1:0]   sstat_reg, sstat_next;
    logic [W-1:0] sepos_reg, sepos_next;
    logic [16:0]  blim_reg;

    logic         ovf;
    logic         do_app;
    logic [7:0]   app_c;
    logic [1:0]   n;
    res_t         r0, r1;
    logic [W-1:0] cts_cl;
    logic [W:0]   tlen;
    logic [W-1:0] esc_pos;
    logic [63:0]  wc64, cts64, tlen64, idx64, esc64, sepos64;
    res_t         tok_res, data_res, line_ok, line_idx, line_esc, line_err;

    // Buffer-full test against min(limit, 2^W)
    assign ovf = (CW'(wc_reg) >= CW'(blim_reg)) || (wc_reg >= BUF_MAX);

    // Token start saturates at the last index; length is fill minus start
    assign cts_cl  = (cts_reg > {1'b0, IDX_MAX}) ? IDX_MAX : cts_reg[W-1:0];
    assign tlen    = wc_reg - cts_reg;
    assign esc_pos = (idx_reg == IDX_MAX || idx_reg == '0) ? idx_reg : idx_reg - 1'b1;

    assign wc64    = 64'(wc_reg);
    assign cts64   = 64'(cts_cl);
    assign tlen64  = 64'(tlen);
    assign idx64   = 64'(idx_reg);
    assign esc64   = 64'(esc_pos);
    assign sepos64 = 64'(sepos_reg);

    // Prebuilt result words
    always_comb
    begin
        tok_res              = '0;
        tok_res.kind         = KIND_TOKEN;
        tok_res.token_start  = cts64[15:0];
        tok_res.token_length = tlen64[16:0];

        data_res             = '0;
        data_res.kind        = KIND_DATA;
        data_res.data_byte   = app_c;
        data_res.byte_index  = wc64[15:0];

        line_ok              = '0;
        line_ok.kind         = KIND_LINE;
        line_ok.status       = ST_OK;

        line_idx                = line_ok;
        line_idx.status         = ST_UNTERM;
        line_idx.error_position = idx64[15:0];

        line_esc                = line_ok;
        line_esc.status         = ST_UNTERM;
        line_esc.error_position = esc64[15:0];

        line_err                = line_ok;
        line_err.status         = sstat_reg;
        line_err.error_position = (sstat_reg != ST_OK) ? sepos64[15:0] : 16'd0;
    end

    // Next state and results for the byte at the input
    always_comb
    begin
        mode_next  = mode_reg;
        wc_next    = wc_reg;
        cts_next   = cts_reg;
        idx_next   = idx_reg;
        sstat_next = sstat_reg;
        sepos_next = sepos_reg;
        do_app     = 1'b0;
        app_c      = in_byte;
        n          = 2'd0;
        r0         = '0;
        r1         = '0;

        unique case (mode_reg)
            M_BETWEEN:
            begin
                if (in_byte == CH_NUL)
                begin
                    r0 = line_ok;
                    n  = 2'd1;
                end
                else if (in_byte == CH_SP || in_byte == CH_TAB)
                begin
                end
                else if (in_byte == CH_DQ)
                begin
                    cts_next  = wc_reg;
                    mode_next = M_DQ;
                end
                else if (in_byte == CH_SQ)
                begin
                    cts_next  = wc_reg;
                    mode_next = M_SQ;
                end
                else if (in_byte == CH_BS)
                begin
                    cts_next  = wc_reg;
                    mode_next = M_WORD_ESC;
                end
                else
                begin
                    cts_next  = wc_reg;
                    mode_next = M_WORD;
                    do_app    = 1'b1;
                end
            end
            M_WORD:
            begin
                if (in_byte == CH_NUL)
                begin
                    r0 = tok_res;
                    r1 = line_ok;
                    n  = 2'd2;
                end
                else if (in_byte == CH_SP || in_byte == CH_TAB)
                begin
                    r0        = tok_res;
                    n         = 2'd1;
                    mode_next = M_BETWEEN;
                end
                else if (in_byte == CH_BS)
                begin
                    mode_next = M_WORD_ESC;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end
            M_WORD_ESC:
            begin
                // trailing backslash is dropped and the word closes
                if (in_byte == CH_NUL)
                begin
                    r0 = tok_res;
                    r1 = line_ok;
                    n  = 2'd2;
                end
                else
                begin
                    mode_next = M_WORD;
                    do_app    = 1'b1;
                end
            end
            M_SQ:
            begin
                if (in_byte == CH_NUL)
                begin
                    r0 = line_idx;
                    n  = 2'd1;
                end
                else if (in_byte == CH_SQ)
                begin
                    r0        = tok_res;
                    n         = 2'd1;
                    mode_next = M_BETWEEN;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end
            M_DQ:
            begin
                if (in_byte == CH_NUL)
                begin
                    r0 = line_idx;
                    n  = 2'd1;
                end
                else if (in_byte == CH_DQ)
                begin
                    r0        = tok_res;
                    n         = 2'd1;
                    mode_next = M_BETWEEN;
                end
                else if (in_byte == CH_BS)
                begin
                    mode_next = M_DQ_ESC;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end
            M_DQ_ESC:
            begin
                // open escape at line end reports the backslash position
                if (in_byte == CH_NUL)
                begin
                    r0 = line_esc;
                    n  = 2'd1;
                end
                else
                begin
                    if (in_byte == CH_N)
                        app_c = CH_NL;
                    else if (in_byte == CH_T)
                        app_c = CH_TAB;
                    mode_next = M_DQ;
                    do_app    = 1'b1;
                end
            end
            default:
            begin
                // error mode: drop bytes until the line ends
                if (in_byte == CH_NUL)
                begin
                    r0 = line_err;
                    n  = 2'd1;
                end
            end
        endcase

        // Buffer write or overflow
        if (do_app)
        begin
            if (ovf)
            begin
                sstat_next = ST_BUF_FULL;
                sepos_next = idx_reg;
                mode_next  = M_ERROR;
            end
            else
            begin
                r0      = data_res;
                n       = 2'd1;
                wc_next = wc_reg + 1'b1;
            end
        end

        // Line end restores everything but the limit
        if (in_byte == CH_NUL)
        begin
            mode_next  = M_BETWEEN;
            wc_next    = '0;
            cts_next   = '0;
            idx_next   = '0;
            sstat_next = ST_OK;
            sepos_next = '0;
        end
        else if (idx_reg != IDX_MAX)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // Mark the final result of this byte
        if (n == 2'd1)
            r0.last_of_run = 1'b1;
        if (n == 2'd2)
            r1.last_of_run = 1'b1;
    end

    assign push.n  = accept ? n : 2'd0;
    assign push.r0 = r0;
    assign push.r1 = r1;

    // State and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_BETWEEN;
            wc_reg    <= '0;
            cts_reg   <= '0;
            idx_reg   <= '0;
            sstat_reg <= ST_OK;
            sepos_reg <= '0;
            blim_reg  <= BUF_LIMIT_RST;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                wc_reg    <= wc_next;
                cts_reg   <= cts_next;
                idx_reg   <= idx_next;
                sstat_reg <= sstat_next;
                sepos_reg <= sepos_next;
            end
            if (cfg_we)
                blim_reg <= cfg_data;
        end
    end

`ifndef SYNTHESIS
    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_byte == CH_NUL |=> mode_reg == M_BETWEEN && wc_reg == '0
            && idx_reg == '0 && sstat_reg == ST_OK)
        else $error("line end did not clear lexer state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= BUF_MAX && cts_reg <= wc_reg)
        else $error("buffer fill or token start out of range");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> push.r0.kind == KIND_TOKEN && push.r1.kind == KIND_LINE
            && in_byte == CH_NUL)
        else $error("two results must be token end then line end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ssat_outq.sv
`default_nettype none

module ssat_outq
    import ssat_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       has_room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_word
);

    localparam int PW = $clog2(OQ_DEPTH);

    res_t         mem_reg [OQ_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    // room for the two results a single byte can cause
    assign has_room  = (count_reg <= (PW + 1)'(OQ_DEPTH - 2));

    assign count_next = count_reg + (PW + 1)'(push.n) - (PW + 1)'(pop);

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wp_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wp_reg + 1'b1] <= push.r1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + PW'(push.n);
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW + 1)'(OQ_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != (PW + 1)'(OQ_DEPTH) |-> PW'(wp_reg - rp_reg) == count_reg[PW-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/shell_style_argument_tokenizer_top.sv
`default_nettype none

// Shell-style command-line tokenizer. Each input word is one byte of the
// line, and a zero byte ends it. Results come out as data bytes with their
// buffer index, token ends with start and length, and a line-end status
// (ok, unterminated quote, buffer full). A byte is taken every cycle while
// in_ready is high; its results enter a four-entry result queue on the
// same edge, so the first result is visible in the cycle after acceptance.
// Most bytes cause at most one result, giving one byte per cycle sustained
// while output keeps up; a line end closing a bare word makes two results.
// in_ready drops while fewer than two queue entries are free, so the queue
// drain of one result per cycle sets the rate. The user writes the buffer
// limit via cfg_we/cfg_data between lines, unchecked; it resets to 65536.
module shell_style_argument_tokenizer_top
    import ssat_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic [15:0]      token_start,
    output logic [16:0]      token_length,
    output logic [1:0]       status,
    output logic [15:0]      error_position,
    output logic             last_of_run
);

    logic  accept;
    push_t push;
    res_t  out_word;

    assign accept = in_valid && in_ready;

    // Lexer state and per-byte decode
    ssat_lexer #(
        .INDEX_BITS (INDEX_BITS)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push)
    );

    // Result queue
    ssat_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign kind           = out_word.kind;
    assign data_byte      = out_word.data_byte;
    assign byte_index     = out_word.byte_index;
    assign token_start    = out_word.token_start;
    assign token_length   = out_word.token_length;
    assign status         = out_word.status;
    assign error_position = out_word.error_position;
    assign last_of_run    = out_word.last_of_run;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ssat_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_REPORTS = 200;
    localparam int PHASE_ITEMS = 135;
    localparam int NUM_PHASES  = 9;

    // Lexer modes of the predictor
    typedef enum logic [2:0] {
        LX_BETWEEN,
        LX_WORD,
        LX_WORD_ESC,
        LX_SQ,
        LX_DQ,
        LX_DQ_ESC,
        LX_SKIP
    } lex_mode_t;

    // Token predictor plus queue of expected result words
    class token_scoreboard;
        lex_mode_t   mode;
        logic [16:0] limit;
        logic [16:0] wr_cnt;
        logic [16:0] tok_start;
        logic [15:0] in_idx;
        logic [1:0]  err_st;
        logic [15:0] err_pos;
        res_t        exp_q[$];
        res_t        step_q[$];
        int          errors;
        int          reports;

        function new();
            limit   = BUF_LIMIT_RST;
            errors  = 0;
            reports = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = LX_BETWEEN;
            wr_cnt    = '0;
            tok_start = '0;
            in_idx    = '0;
            err_st    = ST_OK;
            err_pos   = '0;
        endfunction

        // Append one output byte, or trip the buffer-full error
        function void put_byte(logic [7:0] c, logic [15:0] idx);
            res_t        r;
            logic [16:0] eff;
            eff = (limit > 17'h10000) ? 17'h10000 : limit;
            if (wr_cnt >= eff) begin
                err_st  = ST_BUF_FULL;
                err_pos = idx;
                mode    = LX_SKIP;
            end
            else begin
                r            = '0;
                r.kind       = KIND_DATA;
                r.data_byte  = c;
                r.byte_index = wr_cnt[15:0];
                step_q.push_back(r);
                wr_cnt++;
            end
        endfunction

        function void put_token_end();
            res_t r;
            r              = '0;
            r.kind         = KIND_TOKEN;
            r.token_start  = (tok_start > 17'h0FFFF) ? 16'hFFFF : tok_start[15:0];
            r.token_length = wr_cnt - tok_start;
            step_q.push_back(r);
        endfunction

        function void put_line_end(logic [1:0] st, logic [15:0] pos);
            res_t r;
            r                = '0;
            r.kind           = KIND_LINE;
            r.status         = st;
            r.error_position = (st != ST_OK) ? pos : '0;
            step_q.push_back(r);
        endfunction

        // Predict the result words of one accepted input word
        function void note_byte(logic [7:0] b);
            logic [15:0] idx;
            logic [7:0]  c;
            res_t        r;
            idx = in_idx;
            step_q.delete();
            case (mode)
                LX_BETWEEN:
                begin
                    if (b == CH_NUL) begin
                        put_line_end(ST_OK, '0);
                    end
                    else if (b != CH_SP && b != CH_TAB) begin
                        tok_start = wr_cnt;
                        if (b == CH_DQ) begin
                            mode = LX_DQ;
                        end
                        else if (b == CH_SQ) begin
                            mode = LX_SQ;
                        end
                        else if (b == CH_BS) begin
                            mode = LX_WORD_ESC;
                        end
                        else begin
                            mode = LX_WORD;
                            put_byte(b, idx);
                        end
                    end
                end
                LX_WORD:
                begin
                    if (b == CH_NUL) begin
                        put_token_end();
                        put_line_end(ST_OK, '0);
                    end
                    else if (b == CH_SP || b == CH_TAB) begin
                        put_token_end();
                        mode = LX_BETWEEN;
                    end
                    else if (b == CH_BS) begin
                        mode = LX_WORD_ESC;
                    end
                    else begin
                        put_byte(b, idx);
                    end
                end
                LX_WORD_ESC:
                begin
                    // trailing backslash is dropped, word closes normally
                    if (b == CH_NUL) begin
                        put_token_end();
                        put_line_end(ST_OK, '0);
                    end
                    else begin
                        mode = LX_WORD;
                        put_byte(b, idx);
                    end
                end
                LX_SQ:
                begin
                    if (b == CH_NUL) begin
                        put_line_end(ST_UNTERM, idx);
                    end
                    else if (b == CH_SQ) begin
                        put_token_end();
                        mode = LX_BETWEEN;
                    end
                    else begin
                        put_byte(b, idx);
                    end
                end
                LX_DQ:
                begin
                    if (b == CH_NUL) begin
                        put_line_end(ST_UNTERM, idx);
                    end
                    else if (b == CH_DQ) begin
                        put_token_end();
                        mode = LX_BETWEEN;
                    end
                    else if (b == CH_BS) begin
                        mode = LX_DQ_ESC;
                    end
                    else begin
                        put_byte(b, idx);
                    end
                end
                LX_DQ_ESC:
                begin
                    // line end after backslash: report at the backslash
                    if (b == CH_NUL) begin
                        put_line_end(ST_UNTERM,
                                     (idx == 16'hFFFF || idx == 16'h0) ? idx : idx - 16'd1);
                    end
                    else begin
                        c = b;
                        if (b == CH_N) begin
                            c = CH_NL;
                        end
                        else if (b == CH_T) begin
                            c = CH_TAB;
                        end
                        mode = LX_DQ;
                        put_byte(c, idx);
                    end
                end
                default:
                begin
                    if (b == CH_NUL) begin
                        put_line_end(err_st, err_pos);
                    end
                end
            endcase

            if (b == CH_NUL) begin
                clear_line();
            end
            else if (in_idx != 16'hFFFF) begin
                in_idx++;
            end

            if (step_q.size() != 0) begin
                r = step_q.pop_back();
                r.last_of_run = 1'b1;
                step_q.push_back(r);
            end
            foreach (step_q[i]) begin
                exp_q.push_back(step_q[i]);
            end
        endfunction

        function void field_diff(string name, logic [16:0] want, logic [16:0] got);
            if (got !== want) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, name, want, got);
                end
                reports++;
            end
        endfunction

        // Compare one delivered result word against the oldest expectation
        function void check_word(res_t got);
            res_t want;
            if (exp_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t: result word, expected none, got kind %0d",
                             $time, got.kind);
                end
                reports++;
                return;
            end
            want = exp_q.pop_front();
            field_diff("kind", 17'(want.kind), 17'(got.kind));
            field_diff("data_byte", 17'(want.data_byte), 17'(got.data_byte));
            field_diff("byte_index", 17'(want.byte_index), 17'(got.byte_index));
            field_diff("token_start", 17'(want.token_start), 17'(got.token_start));
            field_diff("token_length", want.token_length, got.token_length);
            field_diff("status", 17'(want.status), 17'(got.status));
            field_diff("error_position", 17'(want.error_position),
                       17'(got.error_position));
            field_diff("last_of_run", 17'(want.last_of_run), 17'(got.last_of_run));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic [1:0]  status;
    logic [15:0] error_position;
    logic        last_of_run;

    token_scoreboard sb;
    logic [7:0]      line_q[$];
    bit              tx_idle;
    bit              rx_idle;
    int              quiet_cycles;
    int              stall_left;
    int              sent;

    shell_style_argument_tokenizer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .token_start    (token_start),
        .token_length   (token_length),
        .status         (status),
        .error_position (error_position),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (rx_idle && $urandom_range(0, 9) == 0) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: check delivered words, note accepted words, watchdog
    always @(posedge clk)
    begin : monitor
        res_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.kind           = kind_t'(kind);
                got.data_byte      = data_byte;
                got.byte_index     = byte_index;
                got.token_start    = token_start;
                got.token_length   = token_length;
                got.status         = status;
                got.error_position = error_position;
                got.last_of_run    = last_of_run;
                sb.check_word(got);
            end
            if (in_valid && in_ready) begin
                sb.note_byte(in_byte);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
    endtask

    // Hold off input until every expected word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [16:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic [7:0] esc_byte();
        case ($urandom_range(0, 7))
            0:       return CH_N;
            1:       return CH_T;
            2:       return CH_BS;
            3:       return CH_DQ;
            4:       return CH_SQ;
            5:       return CH_SP;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void add_blanks(int n);
        repeat (n) line_q.push_back(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
    endfunction

    function automatic void add_quoted(logic [7:0] q, bit closed);
        logic [7:0] c;
        line_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
            if (q == CH_DQ && $urandom_range(0, 4) == 0) begin
                line_q.push_back(CH_BS);
                line_q.push_back(esc_byte());
            end
            else begin
                do c = 8'($urandom_range(1, 255));
                while (c == q || (q == CH_DQ && c == CH_BS));
                line_q.push_back(c);
            end
        end
        if (closed) begin
            line_q.push_back(q);
        end
    endfunction

    // Random command line: mostly well formed, some broken, some raw noise
    function automatic void build_line();
        int         style;
        int         ntok;
        int         sel;
        int         len;
        logic [7:0] c;
        line_q.delete();
        style = $urandom_range(0, 99);
        if (style < 10) begin
            len = $urandom_range(1, 16);
            repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(CH_NUL);
            return;
        end
        add_blanks($urandom_range(0, 2));
        ntok = $urandom_range(0, 5);
        for (int t = 0; t < ntok; t++) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) begin
                // bare word, with the odd escaped byte
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        line_q.push_back(CH_BS);
                        line_q.push_back(esc_byte());
                    end
                    else begin
                        do begin
                            if ($urandom_range(0, 1) != 0) begin
                                c = 8'($urandom_range(8'h21, 8'h7E));
                            end
                            else begin
                                c = 8'($urandom_range(1, 255));
                            end
                        end while (c == CH_SP || c == CH_TAB || c == CH_BS ||
                                   (i == 0 && (c == CH_SQ || c == CH_DQ)));
                        line_q.push_back(c);
                    end
                end
            end
            else begin
                add_quoted((sel == 1) ? CH_SQ : CH_DQ, 1'b1);
            end
            // quoted tokens may abut the next one
            if (t != ntok - 1 && (sel == 0 || $urandom_range(0, 3) != 0)) begin
                add_blanks($urandom_range(1, 2));
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            add_blanks($urandom_range(1, 2));
        end
        if (style < 25) begin
            case ($urandom_range(0, 2))
                0: add_quoted(($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ, 1'b0);
                1:
                begin
                    add_quoted(CH_DQ, 1'b0);
                    line_q.push_back(CH_BS);
                end
                default: line_q.push_back(CH_BS);
            endcase
        end
        line_q.push_back(CH_NUL);
    endfunction

    initial
    begin
        sb           = new();
        quiet_cycles = 0;
        stall_left   = 0;
        sent         = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_byte      <= '0;
        out_ready    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Escapes, quoting styles, empty and adjacent quotes,
        // trailing backslash in a word
        line_q = '{CH_SP, CH_TAB, "a", CH_BS, CH_SP, CH_TAB, CH_DQ, CH_BS, CH_N,
                   CH_BS, CH_T, CH_BS, CH_BS, CH_BS, CH_DQ, "x", CH_DQ, CH_SQ,
                   CH_DQ, CH_SQ, CH_SQ, CH_SQ, 8'hFF, CH_BS, CH_NUL};
        send_line();
        // Unterminated quotes, backslash at line end in double quotes
        line_q = '{CH_DQ, "q", CH_NUL, CH_DQ, CH_BS, CH_NUL, CH_SQ, CH_NUL};
        send_line();
        // Empty line, lone backslash
        line_q = '{CH_NUL, CH_BS, CH_NUL};
        send_line();

        // Random lines under a range of buffer limits
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0:       write_limit(17'd1);
                1:       write_limit(17'd2);
                2:       write_limit(17'd3);
                3:       write_limit(17'($urandom_range(4, 12)));
                4:       write_limit(17'($urandom_range(4, 40)));
                5:       write_limit(17'($urandom_range(41, 300)));
                6:       write_limit(17'($urandom_range(301, 65535)));
                7:       write_limit(17'h10000);
                default: write_limit(17'($urandom_range(1, 8)));
            endcase
            if (p == 0) begin
                // buffer full mid word, and after a closed quote
                tx_idle = 1'b1;
                rx_idle = 1'b1;
                line_q = '{"a", "b", CH_NUL, CH_SQ, "x", CH_SQ, "y", CH_NUL};
                send_line();
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                tx_idle = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                rx_idle = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                build_line();
                send_line();
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ssat_pkg.sv
hw/rtl/ssat_lexer.sv
hw/rtl/ssat_outq.sv
hw/rtl/shell_style_argument_tokenizer_top.sv
tb/tb.sv
